// ===== hdl/bpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// bpsd_pkg
// Shared types, codes and sizes of the BMP pixel stream decoder.
// ----------------------------------------------------------------------------
package bpsd_pkg;

  localparam int MAX_DIM  = 2048;
  localparam int DIM_W    = $clog2(MAX_DIM + 1);
  localparam int COUNT_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ORIGIN_W = 11;
  localparam int COORD_W  = 12;
  localparam int SUM_W    = ((COUNT_W > ORIGIN_W) ? COUNT_W : ORIGIN_W) + 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [7:0]  SIG_B      = 8'h42;
  localparam logic [7:0]  SIG_M      = 8'h4d;
  localparam logic [5:0]  OFF_SIG    = 6'h01;
  localparam logic [5:0]  OFF_WIDTH  = 6'h12;
  localparam logic [5:0]  OFF_HEIGHT = 6'h16;
  localparam logic [5:0]  OFF_DEPTH  = 6'h1c;
  localparam logic [5:0]  OFF_LAST   = 6'h35;
  localparam logic [15:0] DEPTH_24   = 16'd24;
  localparam logic [15:0] DEPTH_32   = 16'd32;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXEL  = 2'd1,
    PH_PAD    = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_PIXEL     = 2'd0,
    ST_NOT_BMP   = 2'd1,
    ST_BAD_DEPTH = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 1'b0,
    CFG_ORIGIN_Y = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   column;
    logic [COUNT_W-1:0]   row;
    logic [31:0]          color;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } front_req_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_head_t;

endpackage

// ===== hdl/bpsd_in_if.sv =====
// ----------------------------------------------------------------------------
// bpsd_in_if
// Byte channel carrying the BMP file into the decoder.
// ----------------------------------------------------------------------------
interface bpsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

// ===== hdl/bpsd_out_if.sv =====
// ----------------------------------------------------------------------------
// bpsd_out_if
// Result channel carrying pixels and error reports out of the decoder.
// ----------------------------------------------------------------------------
interface bpsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [31:0] color;

  modport source (output valid, output status, output pixel_x, output pixel_y,
                  output color, input ready);
  modport sink   (input valid, input status, input pixel_x, input pixel_y,
                  input color, output ready);
endinterface

// ===== hdl/bmp_pixel_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// bmp_pixel_stream_decoder_core
// Decodes an uncompressed 24/32-bit BMP byte stream into positioned pixels and error reports.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | beat
//  bytes    | in  | valid/ready   | data_byte, file_start
//  pixels   | out | valid/ready   | status, pixel_x, pixel_y, color
//  cfg      | in  | cfg_we        | cfg_index, cfg_data (origin_x, origin_y)
//
//  One byte per cycle while bytes.ready is high; a pixel passes through the queue and the output register.
//  The parser feeds a two-entry queue, the formatter an output register.
//  bytes.ready drops only while the queue is full behind a stalled output.
//  Synchronous reset clears the parse state, the queue and both origins.
// ----------------------------------------------------------------------------
module bmp_pixel_stream_decoder_core
  import bpsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  bpsd_in_if.sink              bytes,
  bpsd_out_if.source           pixels,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ORIGIN_W-1:0]  cfg_data
);

  front_req_t  req;
  queue_head_t head;
  logic        full;
  logic        pop;

  bpsd_front u_front (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .full  (full),
    .req   (req)
  );

  bpsd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .full (full),
    .head (head),
    .pop  (pop)
  );

  bpsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .pop       (pop),
    .pixels    (pixels)
  );

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (pixels.valid && (pixels.status != ST_PIXEL)) |->
      (pixels.pixel_x == '0 && pixels.pixel_y == '0 && pixels.color == '0))
    else $error("error beat carries nonzero payload");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !bytes.ready |-> pixels.valid)
    else $error("input stalled with no output beat held");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    req.push |-> !full)
    else $error("push into full queue");

endmodule

// ===== hdl/bpsd_front.sv =====
// ----------------------------------------------------------------------------
// bpsd_front
// Byte parser: header decode, checks, pixel gathering and row padding.
// ----------------------------------------------------------------------------
module bpsd_front
  import bpsd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  bpsd_in_if.sink       bytes,
  input  logic          full,
  output front_req_t    req
);

  phase_t               phase, phase_next;
  logic [5:0]           header_offset;
  logic [7:0]           signature_first;
  logic [31:0]          image_width;
  logic [31:0]          image_height;
  logic [15:0]          bits_per_pixel;
  logic [DIM_W-1:0]     wmag;
  logic [DIM_W-1:0]     hmag;
  logic                 flip;
  logic                 per4;
  logic [COUNT_W-1:0]   column_count;
  logic [COUNT_W-1:0]   row_count;
  logic [1:0]           byte_in_pixel;
  logic [1:0]           pad_count;
  logic [23:0]          pixel_bytes;

  logic                 accept;
  phase_t               eff_phase;
  logic [5:0]           eff_off;
  logic [7:0]           b;
  logic                 sig_bad;
  logic                 hdr_last;
  logic [31:0]          wmag32;
  logic [31:0]          hmag32;
  logic                 depth_bad;
  logic                 too_large;
  logic                 dim_zero;
  logic                 pix_last;
  logic [DIM_W-1:0]     col_inc;
  logic [DIM_W-1:0]     row_inc;
  logic                 row_done;
  logic                 img_done;
  logic [1:0]           pad_amt;
  logic [DIM_W-1:0]     ypos_flip;
  logic [1:0]           w_lane;
  logic [1:0]           h_lane;

  assign bytes.ready = !full;
  assign accept      = bytes.valid && !full;
  assign b           = bytes.data_byte;
  assign eff_phase   = bytes.file_start ? PH_HEADER : phase;
  assign eff_off     = bytes.file_start ? 6'd0 : header_offset;

  assign sig_bad   = (eff_off == OFF_SIG) && ((signature_first != SIG_B) || (b != SIG_M));
  assign hdr_last  = (eff_off >= OFF_LAST);
  assign wmag32    = image_width[31]  ? (32'd0 - image_width)  : image_width;
  assign hmag32    = image_height[31] ? (32'd0 - image_height) : image_height;
  assign depth_bad = (bits_per_pixel != DEPTH_24) && (bits_per_pixel != DEPTH_32);
  assign too_large = (wmag32 > 32'(MAX_DIM)) || (hmag32 > 32'(MAX_DIM));
  assign dim_zero  = (wmag32 == 32'd0) || (hmag32 == 32'd0);
  assign w_lane    = 2'(eff_off - OFF_WIDTH);
  assign h_lane    = 2'(eff_off - OFF_HEIGHT);

  assign pix_last  = per4 ? (byte_in_pixel == 2'd3) : (byte_in_pixel == 2'd2);
  assign col_inc   = DIM_W'(column_count) + DIM_W'(1);
  assign row_inc   = DIM_W'(row_count) + DIM_W'(1);
  assign row_done  = (col_inc == wmag);
  assign img_done  = (row_inc == hmag);
  assign pad_amt   = per4 ? 2'd0 : wmag[1:0];
  assign ypos_flip = hmag - DIM_W'(1) - DIM_W'(row_count);

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      case (eff_phase)
        PH_HEADER: begin
          if (sig_bad) begin
            phase_next = PH_DONE;
          end else if (hdr_last) begin
            phase_next = (depth_bad || too_large || dim_zero) ? PH_DONE : PH_PIXEL;
          end else begin
            phase_next = PH_HEADER;
          end
        end
        PH_PIXEL: begin
          if (pix_last && row_done) begin
            if (img_done) begin
              phase_next = PH_DONE;
            end else if (pad_amt != 2'd0) begin
              phase_next = PH_PAD;
            end else begin
              phase_next = PH_PIXEL;
            end
          end else begin
            phase_next = PH_PIXEL;
          end
        end
        PH_PAD:  phase_next = (pad_count <= 2'd1) ? PH_PIXEL : PH_PAD;
        PH_DONE: phase_next = PH_DONE;
        default: phase_next = PH_DONE;
      endcase
    end
  end

  // results
  always_comb begin
    req = '0;
    case (eff_phase)
      PH_HEADER: begin
        if (sig_bad) begin
          req.push         = accept;
          req.entry.status = ST_NOT_BMP;
        end else if (hdr_last && depth_bad) begin
          req.push         = accept;
          req.entry.status = ST_BAD_DEPTH;
        end else if (hdr_last && too_large) begin
          req.push         = accept;
          req.entry.status = ST_TOO_LARGE;
        end
      end
      PH_PIXEL: begin
        req.push         = accept && pix_last;
        req.entry.status = ST_PIXEL;
        req.entry.column = column_count;
        req.entry.row    = flip ? ypos_flip[COUNT_W-1:0] : row_count;
        req.entry.color  = {per4 ? b : 8'd0,
                            (byte_in_pixel == 2'd2) ? b : pixel_bytes[23:16],
                            pixel_bytes[15:0]};
      end
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_offset   <= '0;
      signature_first <= '0;
      image_width     <= '0;
      image_height    <= '0;
      bits_per_pixel  <= '0;
      wmag            <= '0;
      hmag            <= '0;
      flip            <= 1'b0;
      per4            <= 1'b0;
      column_count    <= '0;
      row_count       <= '0;
      byte_in_pixel   <= '0;
      pad_count       <= '0;
      pixel_bytes     <= '0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        case (eff_phase)
          PH_HEADER: begin
            header_offset <= eff_off + 6'd1;
            if (eff_off == 6'd0) begin
              signature_first <= b;
              image_width     <= '0;
              image_height    <= '0;
              bits_per_pixel  <= '0;
            end
            if (eff_off >= OFF_WIDTH && eff_off < OFF_HEIGHT) begin
              image_width[8*w_lane +: 8] <= b;
            end
            if (eff_off >= OFF_HEIGHT && eff_off < OFF_HEIGHT + 6'd4) begin
              image_height[8*h_lane +: 8] <= b;
            end
            if (eff_off == OFF_DEPTH) begin
              bits_per_pixel[7:0] <= b;
            end
            if (eff_off == OFF_DEPTH + 6'd1) begin
              bits_per_pixel[15:8] <= b;
            end
            if (hdr_last) begin
              wmag          <= wmag32[DIM_W-1:0];
              hmag          <= hmag32[DIM_W-1:0];
              flip          <= !image_height[31];
              per4          <= (bits_per_pixel == DEPTH_32);
              column_count  <= '0;
              row_count     <= '0;
              byte_in_pixel <= '0;
              pad_count     <= '0;
              pixel_bytes   <= '0;
            end
          end
          PH_PIXEL: begin
            if (pix_last) begin
              byte_in_pixel <= '0;
              pixel_bytes   <= '0;
              if (row_done) begin
                column_count <= '0;
                row_count    <= row_inc[COUNT_W-1:0];
                pad_count    <= pad_amt;
              end else begin
                column_count <= col_inc[COUNT_W-1:0];
              end
            end else begin
              byte_in_pixel <= byte_in_pixel + 2'd1;
              case (byte_in_pixel)
                2'd0:    pixel_bytes[7:0]   <= b;
                2'd1:    pixel_bytes[15:8]  <= b;
                2'd2:    pixel_bytes[23:16] <= b;
                default: pixel_bytes        <= pixel_bytes;
              endcase
            end
          end
          PH_PAD: begin
            if (pad_count != 2'd0) begin
              pad_count <= pad_count - 2'd1;
            end
          end
          default: pad_count <= pad_count;
        endcase
      end
    end
  end

endmodule

// ===== hdl/bpsd_queue.sv =====
// ----------------------------------------------------------------------------
// bpsd_queue
// Two-entry queue between the parser and the result formatter.
// ----------------------------------------------------------------------------
module bpsd_queue
  import bpsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  front_req_t  req,
  output logic        full,
  output queue_head_t head,
  input  logic        pop
);

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign full       = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.entry = slots[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (req.push) begin
      slots[wr_ptr] <= req.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (req.push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({req.push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/bpsd_back.sv =====
// ----------------------------------------------------------------------------
// bpsd_back
// Result formatter: origin offset, error zeroing and output register.
// ----------------------------------------------------------------------------
module bpsd_back
  import bpsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ORIGIN_W-1:0]  cfg_data,
  input  queue_head_t          head,
  output logic                 pop,
  bpsd_out_if.source           pixels
);

  logic [ORIGIN_W-1:0] origin_x;
  logic [ORIGIN_W-1:0] origin_y;
  logic                valid;
  logic [SUM_W-1:0]    x_sum;
  logic [SUM_W-1:0]    y_sum;
  logic                is_pixel;

  assign pop      = head.valid && (!valid || pixels.ready);
  assign is_pixel = (head.entry.status == ST_PIXEL);
  assign x_sum    = SUM_W'(head.entry.column) + SUM_W'(origin_x);
  assign y_sum    = SUM_W'(head.entry.row) + SUM_W'(origin_y);

  assign pixels.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X: origin_x <= cfg_data;
        CFG_ORIGIN_Y: origin_y <= cfg_data;
        default:      origin_x <= origin_x;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pop) begin
      valid <= 1'b1;
    end else if (pixels.ready) begin
      valid <= 1'b0;
    end
  end

  // hold the beat until taken
  always_ff @(posedge clk) begin
    if (pop) begin
      pixels.status  <= head.entry.status;
      pixels.pixel_x <= is_pixel ? x_sum[COORD_W-1:0] : '0;
      pixels.pixel_y <= is_pixel ? y_sum[COORD_W-1:0] : '0;
      pixels.color   <= is_pixel ? head.entry.color : '0;
    end
  end

endmodule
